[src/byte_stream_hash_32_defines.svh]
// ----------------------------------------------------------------------------
// Byte stream hash assertion macros
// Shared property forms for the checker; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_HASH_32_DEFINES_SVH
`define BYTE_STREAM_HASH_32_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/bsh_pkg.sv]
// ----------------------------------------------------------------------------
// Byte stream hash package
// Shared types, constants and round tables of the streaming lookup2 hash.
// ----------------------------------------------------------------------------
package bsh_pkg;

	localparam int unsigned BSH_QUEUE_DEPTH = 4;

	localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;
	localparam logic [3:0]  BLOCK_LAST  = 4'd11;
	localparam logic [3:0]  LAST_ROUND  = 4'd8;

	// What the front found in an item; idle items never get this far.
	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_BYTE_END,
		KIND_END
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
	} item_t;

	typedef enum logic [1:0] {
		MIX_A,
		MIX_B,
		MIX_C
	} mix_word_t;

	typedef struct packed {
		logic        start;
		logic        fresh;
		logic        final_mix;
		logic [31:0] init_c;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] extra;
	} mix_cmd_t;

	typedef struct packed {
		logic ready;
		logic done_final;
	} mix_stat_t;

	function automatic mix_word_t round_word(input logic [3:0] r);
		mix_word_t w;
		unique case (r)
			4'd0, 4'd3, 4'd6: w = MIX_A;
			4'd1, 4'd4, 4'd7: w = MIX_B;
			default:          w = MIX_C;
		endcase
		return w;
	endfunction

	function automatic logic [4:0] round_shift(input logic [3:0] r);
		logic [4:0] s;
		unique case (r)
			4'd0:    s = 5'd13;
			4'd1:    s = 5'd8;
			4'd2:    s = 5'd13;
			4'd3:    s = 5'd12;
			4'd4:    s = 5'd16;
			4'd5:    s = 5'd5;
			4'd6:    s = 5'd3;
			4'd7:    s = 5'd10;
			default: s = 5'd15;
		endcase
		return s;
	endfunction

endpackage

[src/bsh_front.sv]
// ----------------------------------------------------------------------------
// Byte stream hash front end
// Accepts items, drops idle ones and tags the rest by kind for the queue.
// ----------------------------------------------------------------------------
module bsh_front import bsh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] data_byte,
	input  logic       byte_valid,
	input  logic       last,
	output logic       push,
	output item_t      push_item,
	input  logic       queue_full
);

	logic  valid_s1;
	item_t item_s1;
	kind_t kind;

	assign item_stall = valid_s1 & queue_full;
	assign push       = valid_s1 & ~queue_full;
	assign push_item  = item_s1;

	always_comb begin
		priority if (byte_valid && last) begin
			kind = KIND_BYTE_END;
		end else if (byte_valid) begin
			kind = KIND_BYTE;
		end else begin
			kind = KIND_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			// drop a beat that carries neither a byte nor an end mark
			valid_s1 <= item_valid & (byte_valid | last);
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			item_s1.kind      <= kind;
			item_s1.data_byte <= data_byte;
		end
	end

endmodule

[src/bsh_queue.sv]
// ----------------------------------------------------------------------------
// Byte stream hash item queue
// Short FIFO between the front end and the hashing back end.
// ----------------------------------------------------------------------------
module bsh_queue import bsh_pkg::*; #(
	parameter int unsigned DEPTH = BSH_QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[src/bsh_mixer.sv]
// ----------------------------------------------------------------------------
// Byte stream hash mixer
// Holds the a, b, c words; adds a block in, then runs nine mix rounds.
// ----------------------------------------------------------------------------
module bsh_mixer import bsh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mix_cmd_t    cmd,
	output mix_stat_t   stat,
	output logic [31:0] result
);

	logic        busy_q;
	logic        final_q;
	logic [3:0]  round_q;
	logic [31:0] a_q, b_q, c_q;
	logic [31:0] tgt, sub_p, sub_q, shifted, new_word;
	logic [4:0]  amount;
	mix_word_t   word_sel;

	// One row of the mix: t = (t - p - q) ^ shift(q); b rows shift left.
	always_comb begin
		word_sel = round_word(round_q);
		amount   = round_shift(round_q);
		unique case (word_sel)
			MIX_A: begin
				tgt = a_q; sub_p = b_q; sub_q = c_q;
			end
			MIX_B: begin
				tgt = b_q; sub_p = c_q; sub_q = a_q;
			end
			MIX_C: begin
				tgt = c_q; sub_p = a_q; sub_q = b_q;
			end
			default: begin
				tgt = a_q; sub_p = b_q; sub_q = c_q;
			end
		endcase
		shifted  = (word_sel == MIX_B) ? (sub_q << amount) : (sub_q >> amount);
		new_word = (tgt - sub_p - sub_q) ^ shifted;
	end

	assign result          = new_word;
	assign stat.ready      = ~busy_q;
	assign stat.done_final = busy_q & final_q & (round_q == LAST_ROUND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			final_q <= 1'b0;
			round_q <= '0;
		end else if (cmd.start && !busy_q) begin
			busy_q  <= 1'b1;
			final_q <= cmd.final_mix;
			round_q <= '0;
		end else if (busy_q) begin
			round_q <= round_q + 1'b1;
			if (round_q == LAST_ROUND) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && !busy_q) begin
			// a new message starts from the golden word and the seed
			a_q <= (cmd.fresh ? GOLDEN_WORD : a_q) + cmd.w0;
			b_q <= (cmd.fresh ? GOLDEN_WORD : b_q) + cmd.w1;
			c_q <= (cmd.fresh ? cmd.init_c : c_q) + cmd.w2 + cmd.extra;
		end else if (busy_q) begin
			unique case (word_sel)
				MIX_A:   a_q <= new_word;
				MIX_B:   b_q <= new_word;
				MIX_C:   c_q <= new_word;
				default: a_q <= new_word;
			endcase
		end
	end

endmodule

[src/bsh_back.sv]
// ----------------------------------------------------------------------------
// Byte stream hash back end
// Packs bytes into block words, tracks length, issues mixes, holds the result.
// ----------------------------------------------------------------------------
module bsh_back import bsh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  item_t       head_item,
	output logic        pop,
	input  logic [31:0] initial_value,
	output mix_cmd_t    cmd,
	input  mix_stat_t   stat,
	input  logic [31:0] result,
	output logic        hash_valid,
	input  logic        hash_stall,
	output logic [31:0] hash_value
);

	logic        open_q;
	logic        byte_done_q;
	logic        fresh_q;
	logic [3:0]  pos_q;
	logic [31:0] len_q;
	logic [31:0] init_q;
	logic [31:0] w0_q, w1_q, w2_q;
	logic        hash_valid_q;
	logic [31:0] hash_q;

	logic        fresh_e;
	logic [3:0]  pos_e;
	logic [31:0] len_e, init_e, w0_e, w1_e, w2_e;
	logic [31:0] w0_nx, w1_nx, w2_nx;
	logic        has_byte, is_end, block_end, out_free, byte_go, end_go;
	logic [4:0]  lane_lsb;

	always_comb begin
		// a closed message reads as freshly opened
		fresh_e = open_q ? fresh_q : 1'b1;
		pos_e   = open_q ? pos_q : '0;
		len_e   = open_q ? len_q : '0;
		init_e  = open_q ? init_q : initial_value;
		w0_e    = open_q ? w0_q : '0;
		w1_e    = open_q ? w1_q : '0;
		w2_e    = open_q ? w2_q : '0;

		has_byte  = (head_item.kind != KIND_END) & ~byte_done_q;
		is_end    = (head_item.kind != KIND_BYTE);
		block_end = (pos_e == BLOCK_LAST);
		out_free  = ~hash_valid_q | ~hash_stall;
		byte_go   = head_valid & has_byte & (~block_end | stat.ready);
		end_go    = head_valid & ~has_byte & is_end & stat.ready & out_free;
		// a byte with an end mark stays at the head for its end step
		pop       = (byte_go & ~is_end) | end_go;

		lane_lsb = {pos_e[1:0], 3'b000};
		w0_nx    = w0_e;
		w1_nx    = w1_e;
		w2_nx    = w2_e;
		if (block_end) begin
			w0_nx = '0;
			w1_nx = '0;
			w2_nx = '0;
		end else begin
			unique case (pos_e[3:2])
				2'd0:    w0_nx[lane_lsb +: 8] = head_item.data_byte;
				2'd1:    w1_nx[lane_lsb +: 8] = head_item.data_byte;
				2'd2:    w2_nx[lane_lsb +: 8] = head_item.data_byte;
				default: w2_nx = w2_e;
			endcase
		end

		cmd.start     = (byte_go & block_end) | end_go;
		cmd.fresh     = fresh_e;
		cmd.final_mix = end_go;
		cmd.init_c    = init_e;
		cmd.w0        = w0_e;
		cmd.w1        = w1_e;
		// tail bytes of the c word leave its low byte free
		cmd.w2        = end_go ? {w2_e[23:0], 8'h00} : {head_item.data_byte, w2_e[23:0]};
		cmd.extra     = end_go ? len_e : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q       <= 1'b0;
			byte_done_q  <= 1'b0;
			fresh_q      <= 1'b1;
			pos_q        <= '0;
			len_q        <= '0;
			hash_valid_q <= 1'b0;
		end else begin
			if (byte_go) begin
				open_q      <= 1'b1;
				byte_done_q <= is_end;
				fresh_q     <= fresh_e & ~block_end;
				pos_q       <= block_end ? '0 : pos_e + 1'b1;
				len_q       <= len_e + 1'b1;
			end else if (end_go) begin
				open_q      <= 1'b0;
				byte_done_q <= 1'b0;
				pos_q       <= '0;
			end
			if (stat.done_final) begin
				hash_valid_q <= 1'b1;
			end else if (!hash_stall) begin
				hash_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_go) begin
			init_q <= init_e;
			w0_q   <= w0_nx;
			w1_q   <= w1_nx;
			w2_q   <= w2_nx;
		end
		if (stat.done_final) begin
			hash_q <= result;
		end
	end

	assign hash_valid = hash_valid_q;
	assign hash_value = hash_q;

endmodule

[src/byte_stream_hash_32.sv]
// ----------------------------------------------------------------------------
// Byte stream hash, 32 bit
// Streaming lookup2 hash of a byte message, one byte per beat.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------
//  item     | item_valid / item_stall     | data_byte, byte_valid, last
//  hash     | hash_valid / hash_stall     | hash_value
//  config   | cfg_valid / cfg_ready       | initial_value
//
//  Bytes are taken one per cycle while item_stall is low; a block mix runs in
//  the mixer in the shadow of the next 12 bytes.
//  Each message ends with a final mix (after an extra end step when the last
//  beat carries a byte); the item queue keeps taking beats meanwhile.
//  The hash appears when the final mix is done, and holds under stall.
//  Reset clears all control state at once; no clearing pass.
// ----------------------------------------------------------------------------
module byte_stream_hash_32 import bsh_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = BSH_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last,
	output logic        hash_valid,
	input  logic        hash_stall,
	output logic [31:0] hash_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] initial_value
);

	logic        push;
	item_t       push_item;
	logic        queue_full;
	logic        pop;
	logic        head_valid;
	item_t       head_item;
	mix_cmd_t    cmd;
	mix_stat_t   stat;
	logic [31:0] result;
	logic [31:0] seed_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= initial_value;
		end
	end

	bsh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.push       (push),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	bsh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	bsh_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.initial_value (seed_q),
		.cmd           (cmd),
		.stat          (stat),
		.result        (result),
		.hash_valid    (hash_valid),
		.hash_stall    (hash_stall),
		.hash_value    (hash_value)
	);

	bsh_mixer u_mixer (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

[src/bsh_checker.sv]
// ----------------------------------------------------------------------------
// Byte stream hash port checker
// Watches the top-level ports for reset behavior, output hold and known hashes.
// ----------------------------------------------------------------------------
`include "byte_stream_hash_32_defines.svh"

module bsh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        hash_valid,
	input logic        hash_stall,
	input logic [31:0] hash_value
);

	// a stalled hash beat holds its value
	`BSH_ASSERT_NEXT(a_hash_hold, hash_valid && hash_stall, hash_valid && $stable(hash_value), "hash beat dropped or changed under stall")

	// no result straight out of reset
	`BSH_ASSERT_NOW(a_reset_quiet, $rose(arst_n), !hash_valid, "hash valid right after reset")

	// a hash beat never carries unknown bits
	`BSH_ASSERT_NOW(a_hash_known, hash_valid, !$isunknown(hash_value), "hash beat carries unknown bits")

endmodule

bind byte_stream_hash_32 bsh_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.hash_valid (hash_valid),
	.hash_stall (hash_stall),
	.hash_value (hash_value)
);

[dv/byte_stream_hash_32_checker.sv]
// ----------------------------------------------------------------------------
// Byte stream hash checker
// Watches the item, hash and config channels of the streaming lookup2 hash,
// predicts each message hash from the accepted beats and compares it with
// the hash beats that the block delivers, in order.
// ----------------------------------------------------------------------------
module byte_stream_hash_32_checker import bsh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last,
	input  logic        hash_valid,
	input  logic        hash_stall,
	input  logic [31:0] hash_value,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	logic [31:0] seed_c;
	logic [31:0] acc_a, acc_b, acc_c;
	logic [31:0] msg_len;
	logic [3:0]  blk_pos;
	logic [7:0]  tail_hi [0:2];
	logic        msg_open;

	logic [31:0] pending_hashes [$];
	logic [31:0] predicted_hash;
	logic [31:0] wanted_hash;

	function automatic void lookup2_mix(inout logic [31:0] a, inout logic [31:0] b,
			inout logic [31:0] c);
		a = (a - b - c) ^ (c >> 13);
		b = (b - c - a) ^ (a << 8);
		c = (c - a - b) ^ (b >> 13);
		a = (a - b - c) ^ (c >> 12);
		b = (b - c - a) ^ (a << 16);
		c = (c - a - b) ^ (b >> 5);
		a = (a - b - c) ^ (c >> 3);
		b = (b - c - a) ^ (a << 10);
		c = (c - a - b) ^ (b >> 15);
	endfunction

	// Fold one accepted beat into the running hash; return 1 when it ends a message.
	function automatic bit absorb_beat(input logic [7:0] b, input logic bv, input logic lst,
			output logic [31:0] h);
		logic [3:0] p;
		h = '0;
		if (!bv && !lst)
			return 1'b0;
		if (!msg_open) begin
			acc_a    = GOLDEN_WORD;
			acc_b    = GOLDEN_WORD;
			acc_c    = seed_c;
			msg_len  = '0;
			blk_pos  = '0;
			msg_open = 1'b1;
		end
		if (bv) begin
			p = blk_pos;
			if (p < 4'd4) begin
				acc_a = acc_a + ({24'd0, b} << (8 * p));
			end else if (p < 4'd8) begin
				acc_b = acc_b + ({24'd0, b} << (8 * (p - 4'd4)));
			end else if (p < 4'd11) begin
				tail_hi[2'(p - 4'd8)] = b;
			end else begin
				acc_c = acc_c + {b, tail_hi[2], tail_hi[1], tail_hi[0]};
				lookup2_mix(acc_a, acc_b, acc_c);
			end
			blk_pos = (p >= 4'd11) ? 4'd0 : p + 4'd1;
			msg_len = msg_len + 32'd1;
		end
		if (!lst)
			return 1'b0;
		// c's low byte stays free for the length; held bytes move up one lane
		acc_c = acc_c + msg_len;
		if (blk_pos > 4'd8)
			acc_c = acc_c + {16'd0, tail_hi[0], 8'd0};
		if (blk_pos > 4'd9)
			acc_c = acc_c + {8'd0, tail_hi[1], 16'd0};
		if (blk_pos > 4'd10)
			acc_c = acc_c + {tail_hi[2], 24'd0};
		lookup2_mix(acc_a, acc_b, acc_c);
		h        = acc_c;
		msg_open = 1'b0;
		blk_pos  = '0;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_c      = '0;
			acc_a       = '0;
			acc_b       = '0;
			acc_c       = '0;
			msg_len     = '0;
			blk_pos     = '0;
			msg_open    = 1'b0;
			mismatches  = 0;
			outstanding = 0;
			pending_hashes.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				seed_c = cfg_data;
			if (item_valid && !item_stall) begin
				if (absorb_beat(data_byte, byte_valid, last, predicted_hash))
					pending_hashes.push_back(predicted_hash);
			end
			if (hash_valid && !hash_stall) begin
				if (pending_hashes.size() == 0) begin
					$error("hash_value: no hash expected, got %h", hash_value);
					mismatches++;
				end else begin
					wanted_hash = pending_hashes.pop_front();
					if (hash_value !== wanted_hash) begin
						$error("hash_value: expected %h, got %h", wanted_hash, hash_value);
						mismatches++;
					end
				end
			end
			outstanding = pending_hashes.size();
		end
	end

endmodule

[dv/byte_stream_hash_32_test.sv]
// ----------------------------------------------------------------------------
// Byte stream hash testbench
// Streams directed and random byte messages into the lookup2 hash under
// random idling on both channels and one long output hold-off, switching
// the initial value between phases; the checker judges every hash beat.
// ----------------------------------------------------------------------------
module byte_stream_hash_32_test;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_BEATS   = 255;
	localparam int CYCLE_LIMIT   = 400000;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        last;
	logic        hash_valid;
	logic        hash_stall;
	logic [31:0] hash_value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	int mismatches;
	int outstanding;
	int cycle_count;
	bit quiet;
	bit hold_off_go;

	byte_stream_hash_32 DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.data_byte     (data_byte),
		.byte_valid    (byte_valid),
		.last          (last),
		.hash_valid    (hash_valid),
		.hash_stall    (hash_stall),
		.hash_value    (hash_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.initial_value (cfg_data)
	);

	byte_stream_hash_32_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.last        (last),
		.hash_valid  (hash_valid),
		.hash_stall  (hash_stall),
		.hash_value  (hash_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Hash side: random stall, one long hold-off on request, none while quiet.
	initial begin : hash_side
		int held;
		hash_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_go) begin
				hold_off_go = 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++) begin
					hash_stall <= 1'b1;
					@(negedge clk);
				end
				hash_stall <= 1'b0;
			end else begin
				hash_stall <= !quiet && ($urandom_range(99) < 7);
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic bv, input logic lst);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 7) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		data_byte  <= b;
		byte_valid <= bv;
		last       <= lst;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// Drop valid, drain every expected hash, then let the mixer go quiet.
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_messages(input int target, input int max_len);
		int  count;
		int  len;
		int  i;
		bit  end_on_byte;
		count = 0;
		while (count < target) begin
			len = ($urandom_range(99) < 6) ? $urandom_range(140, 40) :
				$urandom_range(max_len, 0);
			end_on_byte = 1'b0;
			for (i = 0; i < len; i++) begin
				// stray empty beat inside the message
				if ($urandom_range(99) < 5)
					send_item(8'($urandom_range(255)), 1'b0, 1'b0);
				end_on_byte = (i == len - 1) && ($urandom_range(1) == 1);
				send_item(8'($urandom_range(255)), 1'b1, end_on_byte);
				count++;
			end
			if (!end_on_byte) begin
				send_item(8'($urandom_range(255)), 1'b0, 1'b1);
				count++;
			end
		end
	endtask

	initial begin : stimulus
		logic [31:0] seeds [0:5];
		int ph;
		int i;
		quiet       = 1'b0;
		hold_off_go = 1'b0;
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		data_byte   = '0;
		byte_valid  = 1'b0;
		last        = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		seeds[0] = 32'hffff_ffff;
		seeds[1] = $urandom;
		seeds[2] = 32'h8000_0000;
		seeds[3] = $urandom;
		seeds[4] = 32'h0000_0001;
		seeds[5] = $urandom;
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_seed(32'h0000_0000);
		// empty beat with nothing open, then the empty message
		send_item(8'ha5, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b1);
		// full eleven-byte tail with an empty beat inside
		for (i = 0; i < 11; i++) begin
			if (i == 4)
				send_item(8'h5a, 1'b0, 1'b0);
			send_item(8'hff, 1'b1, i == 10);
		end

		for (ph = 0; ph < 6; ph++) begin
			settle();
			write_seed(seeds[ph]);
			quiet = (ph == 4);
			if (ph == 2) begin
				hold_off_go = 1'b1;
				run_messages(PHASE_BEATS, 4);
			end else begin
				run_messages(PHASE_BEATS, 30);
			end
		end
		quiet = 1'b0;
		settle();

		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/bsh_pkg.sv
src/bsh_front.sv
src/bsh_queue.sv
src/bsh_mixer.sv
src/bsh_back.sv
src/byte_stream_hash_32.sv
src/bsh_checker.sv
dv/byte_stream_hash_32_checker.sv
dv/byte_stream_hash_32_test.sv
